// ----- src/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Buffer pool manager package
// Shared field widths, opcode and status codes, and the decoded item that
// travels from the front end to the execution engine.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Default pool size.
  localparam int unsigned NUM_BUFFERS_DEF = 8;

  // Field widths of the request and response items.
  localparam int unsigned OPC_W  = 3;
  localparam int unsigned BIDX_W = 8;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned STAT_W = 2;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [SIZE_W-1:0] BUFFER_BYTES_RST = 16'd64;

  // Register numbers, taken from the word address.
  typedef enum logic {
    REG_BUFFER_BYTES = 1'b0
  } reg_idx_e;

  // Request opcodes as they arrive on the port.
  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC    = 3'd0,
    OP_ALLOC_OW = 3'd1,
    OP_SEND     = 3'd2,
    OP_RECV     = 3'd3,
    OP_QUERY    = 3'd4,
    OP_RELEASE  = 3'd5
  } opcode_e;

  // Operation class after decoding; unused opcodes become CL_BAD.
  typedef enum logic [2:0] {
    CL_ALLOC,
    CL_ALLOC_OW,
    CL_SEND,
    CL_RECV,
    CL_QUERY,
    CL_RELEASE,
    CL_BAD
  } op_cls_e;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_STATE = 2'd2,
    STAT_SIZE  = 2'd3
  } status_e;

  // Lifecycle of one buffer.
  typedef enum logic [1:0] {
    BS_FREE    = 2'd0,
    BS_WRITING = 2'd1,
    BS_QUEUED  = 2'd2,
    BS_READING = 2'd3
  } buf_state_e;

  // Classified item handed from the front end to the engine.
  typedef struct packed {
    op_cls_e            cls;
    logic               in_range;
    logic [BIDX_W-1:0]  idx;
    logic [SIZE_W-1:0]  size;
  } dec_item_t;

endpackage

// ----- src/bpm_if.sv -----
// ----------------------------------------------------------------------------
// Buffer pool manager channel interfaces
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface bpm_req_if
  import bpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [BIDX_W-1:0] buffer_index;
  logic [SIZE_W-1:0] written_size;

  modport source (output valid, output opcode, output buffer_index,
                  output written_size, input ready);
  modport sink   (input valid, input opcode, input buffer_index,
                  input written_size, output ready);
endinterface

interface bpm_rsp_if
  import bpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BIDX_W-1:0] result_index;
  logic [SIZE_W-1:0] data_length;

  modport source (output valid, output status, output result_index,
                  output data_length, input ready);
  modport sink   (input valid, input status, input result_index,
                  input data_length, output ready);
endinterface

// ----- src/bpm_front.sv -----
// ----------------------------------------------------------------------------
// Buffer pool manager front end
// Accepts request items, classifies the opcode and range-checks the index,
// and holds the result in a register until the queue takes it.
// ----------------------------------------------------------------------------
module bpm_front
  import bpm_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpm_req_if.sink    req,
  output logic       push_o,
  output dec_item_t  item_o,
  input  logic       push_ready_i
);

  logic      vld_q, vld_d;
  dec_item_t item_q, item_d;
  op_cls_e   cls;
  logic      take;

  // Opcode classification.
  always_comb begin
    unique case (req.opcode)
      OP_ALLOC:    cls = CL_ALLOC;
      OP_ALLOC_OW: cls = CL_ALLOC_OW;
      OP_SEND:     cls = CL_SEND;
      OP_RECV:     cls = CL_RECV;
      OP_QUERY:    cls = CL_QUERY;
      OP_RELEASE:  cls = CL_RELEASE;
      default:     cls = CL_BAD;
    endcase
  end

  // The stage takes a new item when empty or when its item moves on.
  assign req.ready = !vld_q || push_ready_i;
  assign take      = req.valid && req.ready;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d           = 1'b1;
      item_d.cls      = cls;
      item_d.in_range = ({1'b0, req.buffer_index} < (BIDX_W+1)'(NUM_BUFFERS));
      item_d.idx      = req.buffer_index;
      item_d.size     = req.written_size;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_o = vld_q;
  assign item_o = item_q;

endmodule

// ----- src/bpm_queue.sv -----
// ----------------------------------------------------------------------------
// Buffer pool manager item queue
// Two-entry queue of classified items between the front end and the engine.
// ----------------------------------------------------------------------------
module bpm_queue
  import bpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dec_item_t item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output dec_item_t item_o,
  input  logic      pop_i
);

  dec_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/bpm_engine.sv -----
// ----------------------------------------------------------------------------
// Buffer pool manager execution engine
// Holds the buffer states, the length memory and the commit FIFO, carries out
// one classified item at a time and registers its response.
// ----------------------------------------------------------------------------
module bpm_engine
  import bpm_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] buffer_bytes_i,
  input  logic              pop_valid_i,
  input  dec_item_t         item_i,
  output logic              pop_o,
  bpm_rsp_if.source         rsp
);

  localparam int unsigned IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_BUFFERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BUFFERS);

  typedef enum logic [1:0] {
    E_IDLE,
    E_EXEC,
    E_LEN
  } eng_state_e;

  // Control and bookkeeping registers.
  eng_state_e        fsm_q, fsm_d;
  dec_item_t         cur_q, cur_d;
  buf_state_e        bstate_q [NUM_BUFFERS];
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rsp_vld_q, rsp_vld_d;
  status_e           rsp_stat_q, rsp_stat_d;
  logic [BIDX_W-1:0] rsp_idx_q, rsp_idx_d;
  logic [SIZE_W-1:0] rsp_len_q, rsp_len_d;

  // Memories and their registered read data.
  logic [SIZE_W-1:0] len_mem [NUM_BUFFERS];
  logic [IDX_W-1:0]  fifo_mem [NUM_BUFFERS];
  logic [SIZE_W-1:0] len_rd_q;
  logic [IDX_W-1:0]  fifo_rd_q;

  // Strobes produced by the sequencer.
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  buf_state_e        st_wval;
  logic              len_we;
  logic [IDX_W-1:0]  len_waddr;
  logic [SIZE_W-1:0] len_wdata;
  logic              len_re;
  logic [IDX_W-1:0]  len_raddr;
  logic              fifo_re;
  logic              push;
  logic              pop_fifo;

  logic [NUM_BUFFERS-1:0] free_vec;
  logic [NUM_BUFFERS-1:0] queued_vec;
  logic                   any_free;
  logic [IDX_W-1:0]       first_free;
  logic [IDX_W-1:0]       cur_idx;
  buf_state_e             cur_st;
  logic                   out_free;

  // Free and queued maps of the pool.
  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      free_vec[i]   = (bstate_q[i] == BS_FREE);
      queued_vec[i] = (bstate_q[i] == BS_QUEUED);
    end
  end

  // Lowest free buffer: priority encoder from the top down.
  always_comb begin
    first_free = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first_free = IDX_W'(i);
      end
    end
  end
  assign any_free = |free_vec;

  assign cur_idx  = cur_q.idx[IDX_W-1:0];
  assign cur_st   = cur_q.in_range ? bstate_q[cur_idx] : BS_FREE;
  assign out_free = !rsp_vld_q || rsp.ready;

  // Sequencer: fetch an item and read the memories, then execute it.
  always_comb begin
    fsm_d      = fsm_q;
    cur_d      = cur_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rsp_vld_d  = rsp_vld_q && !rsp.ready;
    rsp_stat_d = rsp_stat_q;
    rsp_idx_d  = rsp_idx_q;
    rsp_len_d  = rsp_len_q;
    pop_o      = 1'b0;
    st_we      = 1'b0;
    st_waddr   = cur_idx;
    st_wval    = BS_FREE;
    len_we     = 1'b0;
    len_waddr  = cur_idx;
    len_wdata  = '0;
    len_re     = 1'b0;
    len_raddr  = '0;
    fifo_re    = 1'b0;
    push       = 1'b0;
    pop_fifo   = 1'b0;

    unique case (fsm_q)
      E_IDLE: begin
        if (pop_valid_i) begin
          pop_o     = 1'b1;
          cur_d     = item_i;
          fifo_re   = 1'b1;
          len_re    = 1'b1;
          len_raddr = item_i.in_range ? item_i.idx[IDX_W-1:0] : '0;
          fsm_d     = E_EXEC;
        end
      end

      E_EXEC: begin
        if (cur_q.cls == CL_RECV && count_q != '0) begin
          // Pop now; the length read completes in the next cycle.
          pop_fifo  = 1'b1;
          st_we     = 1'b1;
          st_waddr  = fifo_rd_q;
          st_wval   = BS_READING;
          len_re    = 1'b1;
          len_raddr = fifo_rd_q;
          fsm_d     = E_LEN;
        end else if (out_free) begin
          rsp_vld_d  = 1'b1;
          rsp_stat_d = STAT_OK;
          rsp_idx_d  = '0;
          rsp_len_d  = '0;
          fsm_d      = E_IDLE;
          unique case (cur_q.cls)
            CL_ALLOC, CL_ALLOC_OW: begin
              if (any_free) begin
                st_we     = 1'b1;
                st_waddr  = first_free;
                st_wval   = BS_WRITING;
                len_we    = 1'b1;
                len_waddr = first_free;
                rsp_idx_d = BIDX_W'(first_free);
              end else if (cur_q.cls == CL_ALLOC_OW && count_q != '0) begin
                // Pool empty: reclaim the oldest queued buffer.
                pop_fifo  = 1'b1;
                st_we     = 1'b1;
                st_waddr  = fifo_rd_q;
                st_wval   = BS_WRITING;
                len_we    = 1'b1;
                len_waddr = fifo_rd_q;
                rsp_idx_d = BIDX_W'(fifo_rd_q);
              end else begin
                rsp_stat_d = STAT_EMPTY;
              end
            end
            CL_SEND: begin
              if (!cur_q.in_range || cur_st != BS_WRITING) begin
                rsp_stat_d = STAT_STATE;
              end else if (cur_q.size > buffer_bytes_i) begin
                rsp_stat_d = STAT_SIZE;
              end else if (count_q == FULL_CNT) begin
                rsp_stat_d = STAT_EMPTY;
              end else begin
                push      = 1'b1;
                st_we     = 1'b1;
                st_wval   = BS_QUEUED;
                len_we    = 1'b1;
                len_wdata = cur_q.size;
              end
            end
            CL_RECV: begin
              // Only reached with nothing queued.
              rsp_stat_d = STAT_EMPTY;
            end
            CL_QUERY: begin
              if (cur_q.in_range && (cur_st == BS_QUEUED || cur_st == BS_READING)) begin
                rsp_len_d = len_rd_q;
              end else begin
                rsp_stat_d = STAT_STATE;
              end
            end
            CL_RELEASE: begin
              if (cur_q.in_range && (cur_st == BS_WRITING || cur_st == BS_READING)) begin
                st_we   = 1'b1;
                st_wval = BS_FREE;
              end else begin
                rsp_stat_d = STAT_STATE;
              end
            end
            default: begin
              rsp_stat_d = STAT_STATE;
            end
          endcase
        end
      end

      E_LEN: begin
        if (out_free) begin
          rsp_vld_d  = 1'b1;
          rsp_stat_d = STAT_OK;
          rsp_idx_d  = BIDX_W'(fifo_rd_q);
          rsp_len_d  = len_rd_q;
          fsm_d      = E_IDLE;
        end
      end

      default: begin
        fsm_d = E_IDLE;
      end
    endcase

    // FIFO pointer movement.
    if (push) begin
      tail_d  = (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (pop_fifo) begin
      head_d  = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  // State, pointers and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= E_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      rsp_vld_q <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        bstate_q[i] <= BS_FREE;
      end
    end else begin
      fsm_q     <= fsm_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
      if (st_we) begin
        bstate_q[st_waddr] <= st_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    rsp_stat_q <= rsp_stat_d;
    rsp_idx_q  <= rsp_idx_d;
    rsp_len_q  <= rsp_len_d;
  end

  // Length memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_raddr];
    end
  end

  // Commit FIFO memory: written at the tail, read at the head.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[tail_q] <= cur_idx;
    end
    if (fifo_re) begin
      fifo_rd_q <= fifo_mem[head_q];
    end
  end

  assign rsp.valid        = rsp_vld_q;
  assign rsp.status       = rsp_stat_q;
  assign rsp.result_index = rsp_idx_q;
  assign rsp.data_length  = rsp_len_q;

  // The fill count matches the number of buffers in the queued state.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(queued_vec)) == count_q)
    else $error("commit FIFO count differs from queued buffers");

  // The FIFO never holds more entries than there are buffers.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("commit FIFO count overflow");

  // The length fetch for a receive always follows its execute cycle.
  a_len_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fsm_q == E_LEN) |-> $past(fsm_q) == E_EXEC)
    else $error("length fetch entered out of order");

  // A popping receive leaves one entry fewer in the FIFO.
  a_recv_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == E_EXEC && fsm_d == E_LEN) |=> count_q == $past(count_q) - 1'b1)
    else $error("receive did not pop the commit FIFO");

endmodule

// ----- src/buffer_pool_pipe_manager.sv -----
// An item passes the front register and the queue; the engine then fetches it and
// executes it, and a receive that finds a queued buffer also fetches its length.
// The engine takes a new item only once it has registered the last response, since
// it reads the length and FIFO memories before executing.
// A two-entry queue and the front register absorb bursts of up to three items.
// Reset (rst_ni low, asynchronous) frees every buffer, empties the commit FIFO and
// sets buffer_bytes to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Buffer pool manager top level
// Configuration register, front end, item queue and execution engine.
// ----------------------------------------------------------------------------
module buffer_pool_pipe_manager
  import bpm_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  bpm_req_if.sink               req_i,
  bpm_rsp_if.source             rsp_o
);

  logic [SIZE_W-1:0] buffer_bytes_q, buffer_bytes_d;
  logic              reg_sel;
  logic              push;
  logic              push_ready;
  logic              pop;
  logic              pop_valid;
  dec_item_t         front_item;
  dec_item_t         queue_item;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (reg_idx_e'(paddr[2]) == REG_BUFFER_BYTES);

  always_comb begin
    buffer_bytes_d = buffer_bytes_q;
    if (psel && penable && pwrite && reg_sel) begin
      buffer_bytes_d = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_bytes_q <= BUFFER_BYTES_RST;
    end else begin
      buffer_bytes_q <= buffer_bytes_d;
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(buffer_bytes_q) : '0;

  // Front end: accept and classify.
  bpm_front #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .push_o       (push),
    .item_o       (front_item),
    .push_ready_i (push_ready)
  );

  // Decoupling queue.
  bpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (front_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .item_o       (queue_item),
    .pop_i        (pop)
  );

  // Execution engine.
  bpm_engine #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .buffer_bytes_i (buffer_bytes_q),
    .pop_valid_i    (pop_valid),
    .item_i         (queue_item),
    .pop_o          (pop),
    .rsp            (rsp_o)
  );

endmodule
